// File: rtl/core/hre_pkg.sv
`default_nettype none

package hre_pkg;

   // Register file
   localparam int ROW_W    = 63;
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_DST_ROW0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DST_ROW1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DST_ROW2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_ROW0 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_ROW1 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_ROW2 = 3'd5;
   localparam logic [ROW_W-1:0] ROW0_RESET = 63'd1024;
   localparam logic [ROW_W-1:0] ROW1_RESET = 63'd2147483648;
   localparam logic [ROW_W-1:0] ROW2_RESET = 63'h0010_0000_0000_0000;

   // Point mapping
   localparam int COEF_W = 21;
   localparam int PT_W   = 20;
   localparam int PROD_W = COEF_W + PT_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int MAG_W  = 41;
   localparam int FRAC_SHIFT = 18;

   // Divider: dividend is |u|<<18 plus half the divisor
   localparam int DIV_W      = 60;
   localparam int DEN_W      = 41;
   localparam int DIV_STAGES = DIV_W;

   // Distance
   localparam int COORD_W    = DIV_W + 1;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int DMAG_W     = 29;
   localparam int SQ_W       = 2 * DMAG_W;
   localparam int RAD_W      = 60;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int SQRT_STAGES = ROOT_W;
   localparam int SREM_W     = ROOT_W + 2;
   localparam int ERR_W      = 24;
   localparam logic [ERR_W-1:0] ERR_MAX = 24'hFF_FFFF;

   typedef struct packed {
      logic neg;
      logic zero;
   } div_tag_type;

   typedef struct packed {
      logic zero;
      logic sat;
   } sq_tag_type;

endpackage

`default_nettype wire

// File: rtl/core/homography_reprojection_error.sv
`default_nettype none

// Maps a matched point pair through two homographies and reports the distance
// between the projected points in Q20.4, one transaction per clock. A pair is
// taken whenever start is high and busy is low; busy is high only right after
// reset. Pairs with req_keep clear are consumed and produce no result. Each
// result appears on rsp_error/rsp_zero_divisor for exactly one cycle with
// rsp_valid high, in input order; the receiver cannot stall it. A pair passes
// through 3 mapping stages, the 60-stage pipelined divider (one quotient bit
// per stage), 5 distance stages, the 30-stage pipelined square root (one root
// bit per stage) and the output register. Write the csr_ registers only while
// no pair is in flight.

module homography_reprojection_error (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic signed [hre_pkg::PT_W-1:0]      req_first_x,
   input  wire logic signed [hre_pkg::PT_W-1:0]      req_first_y,
   input  wire logic signed [hre_pkg::PT_W-1:0]      req_second_x,
   input  wire logic signed [hre_pkg::PT_W-1:0]      req_second_y,
   input  wire logic                                 req_keep,
   output logic                                      rsp_valid,
   output logic [hre_pkg::ERR_W-1:0]                 rsp_error,
   output logic                                      rsp_zero_divisor,
   input  wire logic                                 csr_we,
   input  wire logic [hre_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [hre_pkg::ROW_W-1:0]            csr_wdata
);

   localparam int NW = hre_pkg::DIV_W;
   localparam int CW = hre_pkg::COORD_W;
   localparam int FW = hre_pkg::DIFF_W;
   localparam int MW = hre_pkg::DMAG_W;
   localparam int QW = hre_pkg::SQ_W;
   localparam int RW = hre_pkg::ROOT_W;
   localparam int EW = RW + 1;

   logic busy_ff;
   logic in_valid;

   logic [hre_pkg::ROW_W-1:0] dst_row0_ff, dst_row1_ff, dst_row2_ff;
   logic [hre_pkg::ROW_W-1:0] src_row0_ff, src_row1_ff, src_row2_ff;

   logic                      ma_valid, mb_valid;
   logic [NW-1:0]             ma_nu, ma_nv, mb_nu, mb_nv;
   logic [hre_pkg::DEN_W-1:0] ma_den, mb_den;
   hre_pkg::div_tag_type      ma_tu, ma_tv, mb_tu, mb_tv;

   logic                      ax_valid, ay_valid, bx_valid, by_valid;
   logic [NW-1:0]             ax_q, ay_q, bx_q, by_q;
   hre_pkg::div_tag_type      ax_t, ay_t, bx_t, by_t;

   logic signed [CW-1:0] ax_in, ay_in, bx_in, by_in;
   logic signed [CW-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [FW-1:0] dx_in, dy_in, dx_ff, dy_ff;
   logic [FW-1:0]        mdx, mdy;
   logic [MW-1:0]        mdx_ff, mdy_ff;
   logic                 sat_in, sat3_ff, sat4_ff, sat5_ff;
   logic [QW-1:0]        sqx_ff, sqy_ff;
   logic [hre_pkg::RAD_W-1:0] sum_ff;
   logic                 zero1_ff, zero2_ff, zero3_ff, zero4_ff, zero5_ff;
   logic                 e1_valid_ff, e2_valid_ff, e3_valid_ff, e4_valid_ff;
   logic                 e5_valid_ff;
   hre_pkg::sq_tag_type  sq_tag;

   logic                 rt_valid;
   logic [RW-1:0]        rt_root;
   hre_pkg::sq_tag_type  rt_tag;
   logic [EW-1:0]        rounded;
   logic [hre_pkg::ERR_W-1:0] error_in, error_ff;
   logic                 rsp_valid_ff, zd_ff;

   // hold off transactions during reset and in the cycle after it
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy     = busy_ff;
   assign in_valid = start & ~busy_ff & req_keep;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dst_row0_ff <= hre_pkg::ROW0_RESET;
         dst_row1_ff <= hre_pkg::ROW1_RESET;
         dst_row2_ff <= hre_pkg::ROW2_RESET;
         src_row0_ff <= hre_pkg::ROW0_RESET;
         src_row1_ff <= hre_pkg::ROW1_RESET;
         src_row2_ff <= hre_pkg::ROW2_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            hre_pkg::REG_DST_ROW0: dst_row0_ff <= csr_wdata;
            hre_pkg::REG_DST_ROW1: dst_row1_ff <= csr_wdata;
            hre_pkg::REG_DST_ROW2: dst_row2_ff <= csr_wdata;
            hre_pkg::REG_SRC_ROW0: src_row0_ff <= csr_wdata;
            hre_pkg::REG_SRC_ROW1: src_row1_ff <= csr_wdata;
            hre_pkg::REG_SRC_ROW2: src_row2_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // project both points
   hre_map u_map_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_x      (req_first_x),
      .in_y      (req_first_y),
      .row0      (dst_row0_ff),
      .row1      (dst_row1_ff),
      .row2      (dst_row2_ff),
      .out_valid (ma_valid),
      .out_num_u (ma_nu),
      .out_num_v (ma_nv),
      .out_den   (ma_den),
      .out_tag_u (ma_tu),
      .out_tag_v (ma_tv)
   );

   hre_map u_map_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_x      (req_second_x),
      .in_y      (req_second_y),
      .row0      (src_row0_ff),
      .row1      (src_row1_ff),
      .row2      (src_row2_ff),
      .out_valid (mb_valid),
      .out_num_u (mb_nu),
      .out_num_v (mb_nv),
      .out_den   (mb_den),
      .out_tag_u (mb_tu),
      .out_tag_v (mb_tv)
   );

   // perspective divides
   hre_div u_div_ax (
      .clock (clock), .reset (reset),
      .in_valid (ma_valid), .in_dividend (ma_nu), .in_divisor (ma_den), .in_tag (ma_tu),
      .out_valid (ax_valid), .out_quot (ax_q), .out_tag (ax_t)
   );

   hre_div u_div_ay (
      .clock (clock), .reset (reset),
      .in_valid (ma_valid), .in_dividend (ma_nv), .in_divisor (ma_den), .in_tag (ma_tv),
      .out_valid (ay_valid), .out_quot (ay_q), .out_tag (ay_t)
   );

   hre_div u_div_bx (
      .clock (clock), .reset (reset),
      .in_valid (mb_valid), .in_dividend (mb_nu), .in_divisor (mb_den), .in_tag (mb_tu),
      .out_valid (bx_valid), .out_quot (bx_q), .out_tag (bx_t)
   );

   hre_div u_div_by (
      .clock (clock), .reset (reset),
      .in_valid (mb_valid), .in_dividend (mb_nv), .in_divisor (mb_den), .in_tag (mb_tv),
      .out_valid (by_valid), .out_quot (by_q), .out_tag (by_t)
   );

   // distance stage 1: restore signs
   always_comb begin
      ax_in = ax_t.neg ? (CW'(0) - $signed({1'b0, ax_q})) : $signed({1'b0, ax_q});
      ay_in = ay_t.neg ? (CW'(0) - $signed({1'b0, ay_q})) : $signed({1'b0, ay_q});
      bx_in = bx_t.neg ? (CW'(0) - $signed({1'b0, bx_q})) : $signed({1'b0, bx_q});
      by_in = by_t.neg ? (CW'(0) - $signed({1'b0, by_q})) : $signed({1'b0, by_q});
   end

   // distance stage 2: differences
   always_comb begin
      dx_in = FW'(ax_ff) - FW'(bx_ff);
      dy_in = FW'(ay_ff) - FW'(by_ff);
   end

   // distance stage 3: magnitudes and range check
   always_comb begin
      mdx    = dx_ff[FW-1] ? (FW'(0) - dx_ff) : dx_ff;
      mdy    = dy_ff[FW-1] ? (FW'(0) - dy_ff) : dy_ff;
      sat_in = (|mdx[FW-1:MW]) | (|mdy[FW-1:MW]);
   end

   // advance distance payload
   always_ff @(posedge clock) begin
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      bx_ff    <= bx_in;
      by_ff    <= by_in;
      zero1_ff <= ax_t.zero | bx_t.zero;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      zero2_ff <= zero1_ff;
      mdx_ff   <= mdx[MW-1:0];
      mdy_ff   <= mdy[MW-1:0];
      sat3_ff  <= sat_in;
      zero3_ff <= zero2_ff;
      sqx_ff   <= QW'(mdx_ff) * QW'(mdx_ff);
      sqy_ff   <= QW'(mdy_ff) * QW'(mdy_ff);
      sat4_ff  <= sat3_ff;
      zero4_ff <= zero3_ff;
      sum_ff   <= hre_pkg::RAD_W'(sqx_ff) + hre_pkg::RAD_W'(sqy_ff);
      sat5_ff  <= sat4_ff;
      zero5_ff <= zero4_ff;
   end

   // advance distance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
         e2_valid_ff <= 1'b0;
         e3_valid_ff <= 1'b0;
         e4_valid_ff <= 1'b0;
         e5_valid_ff <= 1'b0;
      end else begin
         e1_valid_ff <= ax_valid & ay_valid & bx_valid & by_valid;
         e2_valid_ff <= e1_valid_ff;
         e3_valid_ff <= e2_valid_ff;
         e4_valid_ff <= e3_valid_ff;
         e5_valid_ff <= e4_valid_ff;
      end
   end

   assign sq_tag.zero = zero5_ff;
   assign sq_tag.sat  = sat5_ff;

   hre_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (e5_valid_ff),
      .in_radicand (sum_ff),
      .in_tag      (sq_tag),
      .out_valid   (rt_valid),
      .out_root    (rt_root),
      .out_tag     (rt_tag)
   );

   // round to Q.4 and saturate
   always_comb begin
      rounded = (EW'(rt_root) + EW'(8)) >> 4;
      if (rt_tag.zero || rt_tag.sat || (|rounded[EW-1:hre_pkg::ERR_W])) begin
         error_in = hre_pkg::ERR_MAX;
      end else begin
         error_in = rounded[hre_pkg::ERR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      error_ff <= error_in;
      zd_ff    <= rt_tag.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rt_valid;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_error        = error_ff;
   assign rsp_zero_divisor = zd_ff;

`ifndef ASSERT_OFF
   a_zero_saturates: assert property (@(posedge clock)
      rsp_valid && rsp_zero_divisor |-> rsp_error == hre_pkg::ERR_MAX)
      else $error("zero divisor result without saturated error");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

   a_sqrt_latency: assert property (@(posedge clock) disable iff (reset)
      e5_valid_ff |-> ##(hre_pkg::SQRT_STAGES + 1) rsp_valid)
      else $error("transaction lost in square root pipeline");

   a_div_aligned: assert property (@(posedge clock) disable iff (reset)
      ax_valid == bx_valid && ay_valid == by_valid && ax_valid == ay_valid)
      else $error("divider lanes out of step");
`endif

endmodule

`default_nettype wire

// File: rtl/core/hre_map.sv
`default_nettype none

module hre_map (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   input  wire logic signed [hre_pkg::PT_W-1:0]  in_x,
   input  wire logic signed [hre_pkg::PT_W-1:0]  in_y,
   input  wire logic [hre_pkg::ROW_W-1:0]        row0,
   input  wire logic [hre_pkg::ROW_W-1:0]        row1,
   input  wire logic [hre_pkg::ROW_W-1:0]        row2,
   output logic                                  out_valid,
   output logic [hre_pkg::DIV_W-1:0]             out_num_u,
   output logic [hre_pkg::DIV_W-1:0]             out_num_v,
   output logic [hre_pkg::DEN_W-1:0]             out_den,
   output hre_pkg::div_tag_type                  out_tag_u,
   output hre_pkg::div_tag_type                  out_tag_v
);

   localparam int CW = hre_pkg::COEF_W;
   localparam int PW = hre_pkg::PROD_W;
   localparam int SW = hre_pkg::SUM_W;

   logic signed [CW-1:0] c00, c01, c02, c10, c11, c12, c20, c21, c22;

   logic signed [PW-1:0] p00_in, p01_in, p10_in, p11_in, p20_in, p21_in;
   logic signed [PW-1:0] p00_ff, p01_ff, p10_ff, p11_ff, p20_ff, p21_ff;
   logic signed [CW-1:0] k0_ff, k1_ff, k2_ff;
   logic                 v1_ff;

   logic signed [SW-1:0] u_in, v_in, w_in;
   logic signed [SW-1:0] u_ff, v_ff, w_ff;
   logic                 v2_ff;

   logic [SW-1:0]                   ua, va, wa;
   logic [hre_pkg::DEN_W-1:0]       den_in, den_ff;
   logic [hre_pkg::DIV_W-1:0]       nu_in, nv_in, nu_ff, nv_ff;
   hre_pkg::div_tag_type            tu_in, tv_in, tu_ff, tv_ff;
   logic                            v3_ff;

   // unpack coefficients, column 0 lowest
   assign c00 = $signed(row0[0 +: CW]);
   assign c01 = $signed(row0[CW +: CW]);
   assign c02 = $signed(row0[2*CW +: CW]);
   assign c10 = $signed(row1[0 +: CW]);
   assign c11 = $signed(row1[CW +: CW]);
   assign c12 = $signed(row1[2*CW +: CW]);
   assign c20 = $signed(row2[0 +: CW]);
   assign c21 = $signed(row2[CW +: CW]);
   assign c22 = $signed(row2[2*CW +: CW]);

   // stage 1: products
   always_comb begin
      p00_in = c00 * in_x;
      p01_in = c01 * in_y;
      p10_in = c10 * in_x;
      p11_in = c11 * in_y;
      p20_in = c20 * in_x;
      p21_in = c21 * in_y;
   end

   // stage 2: sums with the constant column (1.0 in Q.4, and Q.14 for w)
   always_comb begin
      u_in = SW'(p00_ff) + SW'(p01_ff) + (SW'(k0_ff) <<< 4);
      v_in = SW'(p10_ff) + SW'(p11_ff) + (SW'(k1_ff) <<< 4);
      w_in = SW'(p20_ff) + SW'(p21_ff) + (SW'(k2_ff) <<< 14);
   end

   // stage 3: magnitudes and rounded dividends
   always_comb begin
      ua = u_ff[SW-1] ? (SW'(0) - u_ff) : u_ff;
      va = v_ff[SW-1] ? (SW'(0) - v_ff) : v_ff;
      wa = w_ff[SW-1] ? (SW'(0) - w_ff) : w_ff;
      den_in = wa[hre_pkg::DEN_W-1:0];
      nu_in = {1'b0, ua[hre_pkg::MAG_W-1:0], hre_pkg::FRAC_SHIFT'(0)}
              + hre_pkg::DIV_W'(den_in >> 1);
      nv_in = {1'b0, va[hre_pkg::MAG_W-1:0], hre_pkg::FRAC_SHIFT'(0)}
              + hre_pkg::DIV_W'(den_in >> 1);
      tu_in.neg  = u_ff[SW-1] ^ w_ff[SW-1];
      tu_in.zero = (w_ff == SW'(0));
      tv_in.neg  = v_ff[SW-1] ^ w_ff[SW-1];
      tv_in.zero = (w_ff == SW'(0));
   end

   // advance payload
   always_ff @(posedge clock) begin
      p00_ff <= p00_in;
      p01_ff <= p01_in;
      p10_ff <= p10_in;
      p11_ff <= p11_in;
      p20_ff <= p20_in;
      p21_ff <= p21_in;
      k0_ff  <= c02;
      k1_ff  <= c12;
      k2_ff  <= c22;
      u_ff   <= u_in;
      v_ff   <= v_in;
      w_ff   <= w_in;
      den_ff <= den_in;
      nu_ff  <= nu_in;
      nv_ff  <= nv_in;
      tu_ff  <= tu_in;
      tv_ff  <= tv_in;
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_num_u = nu_ff;
   assign out_num_v = nv_ff;
   assign out_den   = den_ff;
   assign out_tag_u = tu_ff;
   assign out_tag_v = tv_ff;

endmodule

`default_nettype wire

// File: rtl/core/hre_div.sv
`default_nettype none

module hre_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic [hre_pkg::DIV_W-1:0]    in_dividend,
   input  wire logic [hre_pkg::DEN_W-1:0]    in_divisor,
   input  wire hre_pkg::div_tag_type         in_tag,
   output logic                              out_valid,
   output logic [hre_pkg::DIV_W-1:0]         out_quot,
   output hre_pkg::div_tag_type              out_tag
);

   localparam int S  = hre_pkg::DIV_STAGES;
   localparam int NW = hre_pkg::DIV_W;
   localparam int DW = hre_pkg::DEN_W;

   logic [S-1:0]          s_valid, valid_ff;
   logic [DW-1:0]         s_rem [S];
   logic [NW-1:0]         s_nq  [S];
   logic [DW-1:0]         s_den [S];
   hre_pkg::div_tag_type  s_tag [S];
   logic [DW:0]           trial [S];
   logic [DW-1:0]         rem_in [S];
   logic [NW-1:0]         nq_in  [S];
   logic [DW-1:0]         rem_ff [S];
   logic [NW-1:0]         nq_ff  [S];
   logic [DW-1:0]         den_ff [S];
   hre_pkg::div_tag_type  tag_ff [S];

   // one quotient bit per stage: shift in a dividend bit, trial subtract
   always_comb begin
      for (int k = 0; k < S; k++) begin
         if (k == 0) begin
            s_valid[k] = in_valid;
            s_rem[k]   = '0;
            s_nq[k]    = in_dividend;
            s_den[k]   = in_divisor;
            s_tag[k]   = in_tag;
         end else begin
            s_valid[k] = valid_ff[k-1];
            s_rem[k]   = rem_ff[k-1];
            s_nq[k]    = nq_ff[k-1];
            s_den[k]   = den_ff[k-1];
            s_tag[k]   = tag_ff[k-1];
         end
         trial[k] = {s_rem[k], s_nq[k][NW-1]};
         if (trial[k] >= {1'b0, s_den[k]}) begin
            rem_in[k] = DW'(trial[k] - {1'b0, s_den[k]});
            nq_in[k]  = {s_nq[k][NW-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[k][DW-1:0];
            nq_in[k]  = {s_nq[k][NW-2:0], 1'b0};
         end
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      for (int k = 0; k < S; k++) begin
         rem_ff[k] <= rem_in[k];
         nq_ff[k]  <= nq_in[k];
         den_ff[k] <= s_den[k];
         tag_ff[k] <= s_tag[k];
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= s_valid;
      end
   end

   assign out_valid = valid_ff[S-1];
   assign out_quot  = nq_ff[S-1];
   assign out_tag   = tag_ff[S-1];

endmodule

`default_nettype wire

// File: rtl/core/hre_sqrt.sv
`default_nettype none

module hre_sqrt (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic [hre_pkg::RAD_W-1:0]    in_radicand,
   input  wire hre_pkg::sq_tag_type          in_tag,
   output logic                              out_valid,
   output logic [hre_pkg::ROOT_W-1:0]        out_root,
   output hre_pkg::sq_tag_type               out_tag
);

   localparam int S  = hre_pkg::SQRT_STAGES;
   localparam int RW = hre_pkg::RAD_W;
   localparam int QW = hre_pkg::ROOT_W;
   localparam int MW = hre_pkg::SREM_W;

   logic [S-1:0]         s_valid, valid_ff;
   logic [MW-1:0]        s_rem  [S];
   logic [QW-1:0]        s_root [S];
   logic [RW-1:0]        s_rad  [S];
   hre_pkg::sq_tag_type  s_tag  [S];
   logic [MW+1:0]        part   [S];
   logic [MW+1:0]        trial  [S];
   logic [MW-1:0]        rem_in  [S];
   logic [QW-1:0]        root_in [S];
   logic [MW-1:0]        rem_ff  [S];
   logic [QW-1:0]        root_ff [S];
   logic [RW-1:0]        rad_ff  [S];
   hre_pkg::sq_tag_type  tag_ff  [S];

   // one root bit per stage: bring down two radicand bits, try 4q+1
   always_comb begin
      for (int k = 0; k < S; k++) begin
         if (k == 0) begin
            s_valid[k] = in_valid;
            s_rem[k]   = '0;
            s_root[k]  = '0;
            s_rad[k]   = in_radicand;
            s_tag[k]   = in_tag;
         end else begin
            s_valid[k] = valid_ff[k-1];
            s_rem[k]   = rem_ff[k-1];
            s_root[k]  = root_ff[k-1];
            s_rad[k]   = rad_ff[k-1];
            s_tag[k]   = tag_ff[k-1];
         end
         part[k]  = {s_rem[k], s_rad[k][RW-1 -: 2]};
         trial[k] = {2'b00, s_root[k], 2'b01};
         if (part[k] >= trial[k]) begin
            rem_in[k]  = MW'(part[k] - trial[k]);
            root_in[k] = {s_root[k][QW-2:0], 1'b1};
         end else begin
            rem_in[k]  = part[k][MW-1:0];
            root_in[k] = {s_root[k][QW-2:0], 1'b0};
         end
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      for (int k = 0; k < S; k++) begin
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         rad_ff[k]  <= {s_rad[k][RW-3:0], 2'b00};
         tag_ff[k]  <= s_tag[k];
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= s_valid;
      end
   end

   assign out_valid = valid_ff[S-1];
   assign out_root  = root_ff[S-1];
   assign out_tag   = tag_ff[S-1];

endmodule

`default_nettype wire
